// ===== hw/rtl/wtd_pkg.sv =====
package wtd_pkg;

  localparam int MaxWaypoints = 64;
  localparam int IdxW = $clog2(MaxWaypoints);
  localparam int CntW = $clog2(MaxWaypoints + 1);
  localparam int CordicSteps = 16;
  localparam int StepW = $clog2(CordicSteps + 1);
  localparam int SqrtSteps = 18;
  localparam int SqW = $clog2(SqrtSteps + 1);

  localparam logic [CntW-1:0] CntMax = CntW'(MaxWaypoints);

  typedef enum logic [0:0] {
    CMD_LOAD = 1'b0,
    CMD_POSE = 1'b1
  } cmd_t;

  localparam logic [1:0] ADDR_COUNT  = 2'd0;
  localparam logic [1:0] ADDR_WINDOW = 2'd1;
  localparam logic [1:0] ADDR_TOL    = 2'd2;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    case (i)
      5'd0:  atan_turn = 32'd536870912;
      5'd1:  atan_turn = 32'd316933406;
      5'd2:  atan_turn = 32'd167458907;
      5'd3:  atan_turn = 32'd85004756;
      5'd4:  atan_turn = 32'd42667331;
      5'd5:  atan_turn = 32'd21354465;
      5'd6:  atan_turn = 32'd10679838;
      5'd7:  atan_turn = 32'd5340245;
      5'd8:  atan_turn = 32'd2670163;
      5'd9:  atan_turn = 32'd1335087;
      5'd10: atan_turn = 32'd667544;
      5'd11: atan_turn = 32'd333772;
      5'd12: atan_turn = 32'd166886;
      5'd13: atan_turn = 32'd83443;
      5'd14: atan_turn = 32'd41722;
      5'd15: atan_turn = 32'd20861;
      5'd16: atan_turn = 32'd10430;
      5'd17: atan_turn = 32'd5215;
      5'd18: atan_turn = 32'd2608;
      5'd19: atan_turn = 32'd1304;
      5'd20: atan_turn = 32'd652;
      5'd21: atan_turn = 32'd326;
      5'd22: atan_turn = 32'd163;
      5'd23: atan_turn = 32'd81;
      default: atan_turn = 32'd0;
    endcase
  endfunction

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_READ = 6'b000010,
    ST_PREP = 6'b000100,
    ST_ITER = 6'b001000,
    ST_DEC  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

endpackage

// ===== hw/rtl/wtd_cordic.sv =====
module wtd_cordic (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [16:0] dx,
  input  logic signed [16:0] dy,
  output logic               busy,
  output logic signed [15:0] bearing
);

  // x grows by at most ~1.65, 17+8+2 bits are enough
  logic signed [27:0] x_r, y_r;
  logic [31:0] z_r;
  logic [wtd_pkg::StepW-1:0] i_r;
  logic busy_r;
  logic [31:0] zr;

  assign busy = busy_r;
  assign zr = z_r + 32'h8000;
  assign bearing = zr[31:16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      i_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      i_r <= '0;
      if (dx < 0) begin
        x_r <= -(28'(dx) <<< 8);
        y_r <= -(28'(dy) <<< 8);
        z_r <= 32'h8000_0000;
      end else begin
        x_r <= 28'(dx) <<< 8;
        y_r <= 28'(dy) <<< 8;
        z_r <= '0;
      end
    end else if (busy_r) begin
      if (y_r > 0) begin
        x_r <= x_r + (y_r >>> i_r);
        y_r <= y_r - (x_r >>> i_r);
        z_r <= z_r + wtd_pkg::atan_turn(5'(i_r));
      end else begin
        x_r <= x_r - (y_r >>> i_r);
        y_r <= y_r + (x_r >>> i_r);
        z_r <= z_r - wtd_pkg::atan_turn(5'(i_r));
      end
      i_r <= i_r + 1'b1;
      if (i_r == wtd_pkg::StepW'(wtd_pkg::CordicSteps - 1)) busy_r <= 1'b0;
    end
  end

endmodule

// ===== hw/rtl/wtd_isqrt.sv =====
module wtd_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [16:0] ax,
  input  logic [16:0] ay,
  output logic        busy,
  output logic [17:0] root
);

  // square computed in first cycle, then two bits a step
  logic [35:0] n_r;
  logic [17:0] r_r;
  logic [35:0] rem_r;
  logic [wtd_pkg::SqW-1:0] k_r;
  logic busy_r, sq_r;
  logic [37:0] trial;
  logic [35:0] rem_sh;

  assign busy = busy_r;
  assign root = r_r;
  assign rem_sh = {rem_r[33:0], n_r[35:34]};
  assign trial = {2'b0, rem_sh} - {18'b0, r_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      sq_r <= 1'b0;
      k_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      sq_r <= 1'b1;
      n_r <= 36'(ax) * 36'(ax);
      rem_r <= 36'(ay) * 36'(ay);
      k_r <= '0;
    end else if (busy_r && sq_r) begin
      sq_r <= 1'b0;
      n_r <= n_r + rem_r;
      rem_r <= '0;
      r_r <= '0;
    end else if (busy_r) begin
      n_r <= {n_r[33:0], 2'b00};
      if (!trial[37]) begin
        rem_r <= trial[35:0];
        r_r <= {r_r[16:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        r_r <= {r_r[16:0], 1'b0};
      end
      k_r <= k_r + 1'b1;
      if (k_r == wtd_pkg::SqW'(wtd_pkg::SqrtSteps - 1)) busy_r <= 1'b0;
    end
  end

endmodule

// ===== hw/rtl/waypoint_turn_then_drive_top.sv =====
// waypoint follower, turn then drive. a load beat (command 0) writes one table
// slot and gives no result. a pose beat (command 1) gives one result: once the
// plan is finished it is loaded at once, else the current waypoint is read from
// the table memory, then the difference is registered and the iterative units
// are started, after which a cordic (16 steps) for the bearing and an integer
// square root (a squaring step and 18 two-bit steps) for the distance run side
// by side. a wait state sees both units done and the next state loads the output
// register, the square root loop being the longer one. one item is in work at a
// time; the next beat can be taken in the cycle the waiting result leaves.
module waypoint_turn_then_drive_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: entry_index[5:0], entry_x[21:6], entry_y[37:22], pos_x[53:38],
  // pos_y[69:54], heading[85:70], zero fill to 88
  input  logic [87:0] in_tdata,
  // tuser: command
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata: speed[15:0], turn_rate[31:16], target_index[38:32], done_res[39]
  output logic [39:0] out_tdata,
  // tuser: aligned
  output logic        out_tuser,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // configuration registers
  logic [6:0]  count_r;
  logic [14:0] window_r, tol_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 7'd0;
      window_r <= 15'd18;
      tol_r    <= 15'd26;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        wtd_pkg::ADDR_COUNT:  count_r  <= cfg_pwdata[6:0];
        wtd_pkg::ADDR_WINDOW: window_r <= cfg_pwdata[14:0];
        wtd_pkg::ADDR_TOL:    tol_r    <= cfg_pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      wtd_pkg::ADDR_COUNT:  cfg_prdata = {25'd0, count_r};
      wtd_pkg::ADDR_WINDOW: cfg_prdata = {17'd0, window_r};
      wtd_pkg::ADDR_TOL:    cfg_prdata = {17'd0, tol_r};
      default:              cfg_prdata = 32'd0;
    endcase
  end

  // input field unpack
  logic [5:0]         f_idx;
  logic signed [15:0] f_ex, f_ey, f_px, f_py, f_hd;
  assign f_idx = in_tdata[5:0];
  assign f_ex  = in_tdata[21:6];
  assign f_ey  = in_tdata[37:22];
  assign f_px  = in_tdata[53:38];
  assign f_py  = in_tdata[69:54];
  assign f_hd  = in_tdata[85:70];

  // waypoint table: x high, y low
  logic [31:0] table_mem [wtd_pkg::MaxWaypoints];
  logic [31:0] rd_r;

  wtd_pkg::state_t st_r;
  logic [wtd_pkg::CntW-1:0] tgt_r;
  logic locked_r;
  logic signed [15:0] px_r, py_r, hd_r;
  logic signed [16:0] dx_r, dy_r;
  logic [wtd_pkg::CntW-1:0] cnt_eff;
  logic accept;
  logic out_load;

  // a waiting result may leave in the same cycle a new beat comes in
  assign in_tready = (st_r == wtd_pkg::ST_IDLE) && (!out_tvalid || out_tready);
  assign accept = in_tvalid && in_tready;
  // a count past the table is clamped to its size; an index past the table is dropped (only possible at larger widths)
  assign cnt_eff = (wtd_pkg::CntW'(count_r) > wtd_pkg::CntMax) ? wtd_pkg::CntMax
                 : wtd_pkg::CntW'(count_r);

  always_ff @(posedge clk) begin
    if (accept && in_tuser == wtd_pkg::CMD_LOAD && 32'(f_idx) < wtd_pkg::MaxWaypoints)
      table_mem[f_idx[wtd_pkg::IdxW-1:0]] <= {f_ex, f_ey};
    rd_r <= table_mem[tgt_r[wtd_pkg::IdxW-1:0]];
  end

  // iterative units
  logic cor_busy, sq_busy, unit_start;
  logic signed [15:0] bearing;
  logic [17:0] root;
  logic [16:0] ax, ay;
  assign ax = dx_r[16] ? 17'(-dx_r) : 17'(dx_r);
  assign ay = dy_r[16] ? 17'(-dy_r) : 17'(dy_r);
  assign unit_start = (st_r == wtd_pkg::ST_ITER);

  wtd_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .start(unit_start), .dx(dx_r), .dy(dy_r),
    .busy(cor_busy), .bearing(bearing)
  );

  wtd_isqrt u_isqrt (
    .clk(clk), .rst_n(rst_n), .start(unit_start), .ax(ax), .ay(ay),
    .busy(sq_busy), .root(root)
  );

  // decision math
  logic signed [17:0] err;
  logic [16:0] aerr;
  logic [27:0] mag_full;
  logic [15:0] mag;
  logic lock_now, arrive;
  logic [19:0] num;
  logic [22:0] prod;
  logic [16:0] spd_q;
  logic [15:0] spd;
  logic signed [15:0] bear_eff;

  assign bear_eff = (dx_r == 17'sd0 && dy_r == 17'sd0) ? 16'sd0 : bearing;
  assign err = 18'(bear_eff) - 18'(hd_r);
  assign aerr = err[17] ? 17'(-err) : 17'(err);
  assign mag_full = {1'b0, aerr, 10'd0} + 28'd838861;
  assign mag = 16'(mag_full[27:15]);
  assign lock_now = (err < $signed({3'b0, window_r})) && (err > -$signed({3'b0, window_r}));
  assign arrive = (ax <= {2'b0, tol_r}) && (ay <= {2'b0, tol_r});
  // divide by 5: multiply by ceil(2^22/5) for values below 2^20
  assign num = {root, 2'b00} + 20'd128;
  assign prod = 23'((43'(num) * 43'd838861) >> 22);
  assign spd_q = prod[16:0];
  assign spd = (spd_q > 17'd65535) ? 16'hFFFF : spd_q[15:0];

  // output register loads on a finished-plan pose or at the end of a pose
  assign out_load = (accept && in_tuser == wtd_pkg::CMD_POSE && tgt_r >= cnt_eff)
                  || (st_r == wtd_pkg::ST_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= wtd_pkg::ST_IDLE;
      tgt_r <= '0;
      locked_r <= 1'b0;
      out_tvalid <= 1'b0;
    end else begin
      if (out_load) out_tvalid <= 1'b1;
      else if (out_tvalid && out_tready) out_tvalid <= 1'b0;
      unique case (st_r)
        wtd_pkg::ST_IDLE: begin
          if (accept && in_tuser == wtd_pkg::CMD_POSE) begin
            px_r <= f_px;
            py_r <= f_py;
            hd_r <= f_hd;
            if (tgt_r >= cnt_eff) begin
              out_tdata <= {1'b1, 7'(tgt_r), 32'd0};
              out_tuser <= locked_r;
            end else begin
              st_r <= wtd_pkg::ST_READ;
            end
          end
        end
        wtd_pkg::ST_READ: st_r <= wtd_pkg::ST_PREP;
        wtd_pkg::ST_PREP: begin
          dx_r <= 17'(signed'(rd_r[31:16])) - 17'(px_r);
          dy_r <= 17'(signed'(rd_r[15:0])) - 17'(py_r);
          st_r <= wtd_pkg::ST_ITER;
        end
        wtd_pkg::ST_ITER: begin
          // units start on the cycle after dx/dy registered
          st_r <= wtd_pkg::ST_DEC;
        end
        wtd_pkg::ST_DEC: begin
          if (!cor_busy && !sq_busy) st_r <= wtd_pkg::ST_OUT;
        end
        wtd_pkg::ST_OUT: begin
          st_r <= wtd_pkg::ST_IDLE;
          if (!locked_r && !lock_now) begin
            out_tdata <= {1'b0, 7'(tgt_r), 16'(err[17] ? -$signed(mag) : $signed(mag)),
                          16'd0};
            out_tuser <= 1'b0;
          end else begin
            if (arrive) begin
              tgt_r <= tgt_r + 1'b1;
              locked_r <= 1'b0;
              out_tdata <= {1'b0, 7'(tgt_r + 1'b1), 16'd0, spd};
              out_tuser <= 1'b0;
            end else begin
              locked_r <= 1'b1;
              out_tdata <= {1'b0, 7'(tgt_r), 16'd0, spd};
              out_tuser <= 1'b1;
            end
          end
        end
        default: st_r <= wtd_pkg::ST_IDLE;
      endcase
    end
  end

  // unit start does not fire with dx: ST_PREP registers dx, ST_ITER starts
  // (the start pulse above is taken from ST_PREP's successor)
endmodule

// ===== hw/rtl/wtd_checker.sv =====
module wtd_sva (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[39] |-> out_tdata[31:0] == 32'd0)
    else $error("done with motion");

  a_lock_noturn: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[31:16] == 16'd0)
    else $error("aligned but turning");

  a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken over a waiting result");

endmodule

bind waypoint_turn_then_drive_top wtd_sva u_sva (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser)
);
